### design/ogi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid inflation package
// Shared constants and types for the occupancy grid inflation core.
// ----------------------------------------------------------------------------
package ogi_pkg;

  localparam int GridColumnsDefault = 32;
  localparam int GridRowsDefault    = 32;

  // Width of the signed cell coordinates.
  localparam int CoordW = 9;
  // Width of the coordinates plus a walk offset, with room for the sign.
  localparam int SumW = CoordW + 2;

  // One memory word per cell: bit 0 is the obstacle bit, bit 1 the border bit.
  localparam int CellBits  = 2;
  localparam int ObsBit    = 0;
  localparam int BorderBit = 1;

  localparam int RadiusW      = 2;
  localparam int RadiusReset  = 1;
  localparam int ApbAddrW     = 3;
  localparam int ApbDataW     = 32;

  // Register indexes on the configuration port.
  localparam logic [0:0] RegBorderRadius = 1'b0;

  // Request codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_WALK,
    ST_DRAIN
  } state_e;

endpackage

### design/occupancy_grid_inflation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid inflation core
// Keeps an obstacle grid, inflates a safety border around inserted obstacles
// and answers cell queries.
// ----------------------------------------------------------------------------
// Usage: a request transaction (req_type_i, cell_x_i, cell_y_i) is taken on a
// rising edge where start is high and busy is low. Each request gives one
// result transaction, shown for exactly one cycle with result_valid_o high.
// The receiver cannot stall; the result register is free again when busy
// falls, so no result is ever held back.
// Request handling, with N = (2*border_radius+1)^2:
//   cell outside the grid: result in the next cycle, next request at once;
//   query: ST_QUERY, busy, takes the registered memory read, then the result
//   is registered; insert: ST_WALK, busy, walks the N cells of the border
//   square through the cell memory (one read-modify-write per cell inside the
//   grid, registered read), then ST_DRAIN retires the last write and gives the result.
// After reset the core runs a clearing pass over all GRID_COLUMNS*GRID_ROWS
// cells of the cell memory, one cell a cycle, with busy high. Writes on the
// APB port are taken at any time, and border_radius resets to 1.
// ----------------------------------------------------------------------------
module occupancy_grid_inflation_core #(
  parameter int GRID_COLUMNS = ogi_pkg::GridColumnsDefault,
  parameter int GRID_ROWS    = ogi_pkg::GridRowsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type_i,
  input  logic signed [ogi_pkg::CoordW-1:0]   cell_x_i,
  input  logic signed [ogi_pkg::CoordW-1:0]   cell_y_i,
  output logic                                result_valid_o,
  output logic                                in_grid_o,
  output logic                                is_obstacle_cell_o,
  output logic                                is_border_cell_o,
  output logic                                available_o,
  output logic                                status_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ogi_pkg::ApbAddrW-1:0]        paddr,
  input  logic [ogi_pkg::ApbDataW-1:0]        pwdata,
  output logic [ogi_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready
);
  import ogi_pkg::*;

  localparam int CellCount = GRID_COLUMNS * GRID_ROWS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int ColW      = $clog2(GRID_COLUMNS);
  localparam int RowW      = $clog2(GRID_ROWS);

  function automatic logic in_range(logic signed [SumW-1:0] v, int lim);
    return !v[SumW-1] && (v < SumW'(lim));
  endfunction

  function automatic logic [AddrW-1:0] addr_of(logic signed [SumW-1:0] cx,
                                               logic signed [SumW-1:0] cy);
    return AddrW'(cy[RowW-1:0]) * AddrW'(GRID_COLUMNS) + AddrW'(cx[ColW-1:0]);
  endfunction

  state_e state_q, state_d;

  logic [AddrW-1:0]         clr_q, clr_d;
  logic signed [2:0]        dx_q, dx_d, dy_q, dy_d;
  logic signed [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic                     pend_valid_q, pend_valid_d;
  logic [AddrW-1:0]         pend_addr_q, pend_addr_d;
  logic                     pend_center_q, pend_center_d;
  logic [RadiusW-1:0]       radius_q;

  logic res_valid_q, res_valid_d;
  logic res_in_grid_q, res_in_grid_d;
  logic res_obs_q, res_obs_d;
  logic res_border_q, res_border_d;
  logic res_avail_q, res_avail_d;
  logic res_status_q, res_status_d;

  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr, mem_raddr;
  logic [CellBits-1:0]      mem_wdata, mem_rdata;

  logic signed [SumW-1:0]   in_x, in_y, walk_x, walk_y;
  logic                     in_inside, walk_inside, walk_last;
  logic                     accept;
  logic signed [2:0]        rad_s, rad_neg;

  // ---------------------------------------------------------------- config
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(RadiusReset);
    end else if (cfg_write && paddr[2:2] == RegBorderRadius) begin
      radius_q <= pwdata[RadiusW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == RegBorderRadius) begin
      prdata = ApbDataW'(radius_q);
    end
  end

  // ---------------------------------------------------------- coordinates
  assign rad_s   = signed'({1'b0, radius_q});
  assign rad_neg = -rad_s;

  assign in_x      = SumW'(cell_x_i);
  assign in_y      = SumW'(cell_y_i);
  assign in_inside = in_range(in_x, GRID_COLUMNS) && in_range(in_y, GRID_ROWS);

  assign walk_x      = SumW'(x_q) + SumW'(dx_q);
  assign walk_y      = SumW'(y_q) + SumW'(dy_q);
  assign walk_inside = in_range(walk_x, GRID_COLUMNS) && in_range(walk_y, GRID_ROWS);
  assign walk_last   = (dx_q == rad_s) && (dy_q == rad_s);

  assign accept = start && !busy;

  // ---------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AddrW'(CellCount - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_inside) begin
          state_d = (req_type_i == ReqQuery) ? ST_QUERY : ST_WALK;
        end
      end
      ST_QUERY: state_d = ST_IDLE;
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------- outputs
  always_comb begin
    busy          = 1'b1;
    clr_d         = clr_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    x_d           = x_q;
    y_d           = y_q;
    pend_valid_d  = 1'b0;
    pend_addr_d   = pend_addr_q;
    pend_center_d = pend_center_q;
    res_valid_d   = 1'b0;
    res_in_grid_d = res_in_grid_q;
    res_obs_d     = res_obs_q;
    res_border_d  = res_border_q;
    res_avail_d   = res_avail_q;
    res_status_d  = res_status_q;
    mem_raddr     = addr_of(walk_x, walk_y);
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_q;
    mem_wdata     = '0;

    // The pending write retires the registered read issued for its cell. An
    // inserted cell is forced to obstacle without border.
    if (pend_valid_q) begin
      mem_we = 1'b1;
      if (pend_center_q) begin
        mem_wdata[ObsBit]    = 1'b1;
        mem_wdata[BorderBit] = 1'b0;
      end else begin
        mem_wdata[ObsBit]    = mem_rdata[ObsBit];
        mem_wdata[BorderBit] = !mem_rdata[ObsBit];
      end
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
      end
      ST_IDLE: begin
        busy      = 1'b0;
        mem_raddr = addr_of(in_x, in_y);
        if (accept) begin
          x_d  = cell_x_i;
          y_d  = cell_y_i;
          dx_d = rad_neg;
          dy_d = rad_neg;
          if (!in_inside) begin
            res_valid_d   = 1'b1;
            res_in_grid_d = 1'b0;
            res_obs_d     = 1'b0;
            res_border_d  = 1'b0;
            res_avail_d   = 1'b0;
            res_status_d  = (req_type_i == ReqInsert);
          end
        end
      end
      ST_QUERY: begin
        res_valid_d   = 1'b1;
        res_in_grid_d = 1'b1;
        res_obs_d     = mem_rdata[ObsBit];
        res_border_d  = mem_rdata[BorderBit];
        res_avail_d   = !mem_rdata[ObsBit] && !mem_rdata[BorderBit];
        res_status_d  = 1'b0;
      end
      ST_WALK: begin
        pend_valid_d  = walk_inside;
        pend_addr_d   = addr_of(walk_x, walk_y);
        pend_center_d = (dx_q == 3'sd0) && (dy_q == 3'sd0);
        if (dy_q == rad_s) begin
          dy_d = rad_neg;
          dx_d = dx_q + 3'sd1;
        end else begin
          dy_d = dy_q + 3'sd1;
        end
      end
      ST_DRAIN: begin
        // The inserted cell always ends as an obstacle without border.
        res_valid_d   = 1'b1;
        res_in_grid_d = 1'b1;
        res_obs_d     = 1'b1;
        res_border_d  = 1'b0;
        res_avail_d   = 1'b0;
        res_status_d  = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ----------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q          <= dx_d;
    dy_q          <= dy_d;
    x_q           <= x_d;
    y_q           <= y_d;
    pend_addr_q   <= pend_addr_d;
    pend_center_q <= pend_center_d;
    res_in_grid_q <= res_in_grid_d;
    res_obs_q     <= res_obs_d;
    res_border_q  <= res_border_d;
    res_avail_q   <= res_avail_d;
    res_status_q  <= res_status_d;
  end

  ogi_grid_mem #(
    .DEPTH  (CellCount),
    .ADDR_W (AddrW)
  ) u_grid_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign result_valid_o     = res_valid_q;
  assign in_grid_o          = res_in_grid_q;
  assign is_obstacle_cell_o = res_obs_q;
  assign is_border_cell_o   = res_border_q;
  assign available_o        = res_avail_q;
  assign status_o           = res_status_q;

endmodule

### design/ogi_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid cell memory
// Simple dual-port cell store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ogi_grid_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [ogi_pkg::CellBits-1:0] wdata_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [ogi_pkg::CellBits-1:0] rdata_o
);
  import ogi_pkg::*;

  logic [CellBits-1:0] mem_q [DEPTH];
  logic [CellBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
